// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define RRTA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RRTA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rrta_pkg.sv =====
`timescale 1ns / 1ps

package rrta_pkg;

	// Default sizes of the ring and of the car store.
	localparam int ROAD_CELLS_DEF = 1024;
	localparam int MAX_CARS_DEF   = 256;

	// Field widths of the transactions and registers.
	localparam int OP_W         = 1;
	localparam int CAR_ID_W     = 8;
	localparam int CELL_FIELD_W = 10;
	localparam int SPEED_W      = 5;
	localparam int PCT_W        = 7;
	localparam int CAR_COUNT_W  = 9;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAWDLE_PCT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_PCT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAR_COUNT     = 3'd4;

	// Register values after reset.
	localparam logic [SPEED_W-1:0]     MAX_SPEED_RST   = 5'd5;
	localparam logic [PCT_W-1:0]       DAWDLE_PCT_RST  = 7'd20;
	localparam logic [PCT_W-1:0]       RESTART_PCT_RST = 7'd0;
	localparam logic                   CRUISE_RST      = 1'b0;
	localparam logic [CAR_COUNT_W-1:0] CAR_COUNT_RST   = 9'd1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
	localparam logic [OP_W-1:0] OP_STEP = 1'b1;

	// A full probability.
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// Reduces a cell number modulo the ring length by a ladder of
	// compare-and-subtract steps against shifted copies of the length.
	function automatic logic [CELL_FIELD_W-1:0] cell_reduce(
		input logic [CELL_FIELD_W-1:0] cell_in,
		input int unsigned             road
	);
		int unsigned rem;
		int unsigned sub;
		rem = cell_in;
		for (int k = CELL_FIELD_W - 1; k >= 0; k--) begin
			sub = road << k;
			if (sub <= rem) begin
				rem = rem - sub;
			end
		end
		return CELL_FIELD_W'(rem);
	endfunction

endpackage

// ===== rtl/rrta_cmd_if.sv =====
`timescale 1ns / 1ps

// Command channel: car loads and step requests.
interface rrta_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [rrta_pkg::OP_W-1:0]           operation;
	logic [rrta_pkg::CAR_ID_W-1:0]       car_index;
	logic [rrta_pkg::CELL_FIELD_W-1:0]   cell_req;
	logic [rrta_pkg::SPEED_W-1:0]        speed;
	logic [rrta_pkg::PCT_W-1:0]          random_percent;

	modport source (
		output valid, operation, car_index, cell_req, speed, random_percent,
		input  ready
	);

	modport sink (
		input  valid, operation, car_index, cell_req, speed, random_percent,
		output ready
	);
endinterface

// ===== rtl/rrta_rsp_if.sv =====
`timescale 1ns / 1ps

// Result channel: one transaction per car written or stepped.
interface rrta_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [rrta_pkg::CAR_ID_W-1:0]       car_id;
	logic [rrta_pkg::CELL_FIELD_W-1:0]   new_cell;
	logic [rrta_pkg::SPEED_W-1:0]        new_speed;
	logic                                tick_done;

	modport source (
		output valid, car_id, new_cell, new_speed, tick_done,
		input  ready
	);

	modport sink (
		input  valid, car_id, new_cell, new_speed, tick_done,
		output ready
	);
endinterface

// ===== rtl/rrta_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-read RAM: one write port, two read ports, registered read data.
// A read of the address written in the same cycle returns the old contents.
module rrta_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array and read registers; neither is reset.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/ring_road_traffic_automaton_step_unit.sv =====
`timescale 1ns / 1ps
// Ring road traffic automaton, one car per transaction.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while the block is idle.
// The cmd channel carries two kinds of transaction: a load writes one car's cell and speed
// (speed saturated to the speed limit), a step advances the next car of the current tick in
// index order. Each load of a car that exists and each step gives one rsp transaction with
// the car number, its new cell, its new speed and a flag on the last car of a tick.
// Throughput is one transaction per clock while rsp is not stalled: the car state sits in one
// RAM with one write port, and every transaction does one read-modify-write of it. An accepted
// command passes the RAM read registers into the update stage, which writes back and loads the
// output register that presents the result. Back-to-back accesses to the same car are forwarded
// from the write-back stage, so there are no bubbles.
// When rsp is stalled, the output register holds its transaction, one more command can
// still enter the update stage, and cmd.ready then drops until the output register drains.
// Reset restores the register defaults, the step cursor and the saved cell of car 0; the car
// RAM is not cleared and needs no clearing pass: every car must be loaded before it is stepped.

`include "assert_macros.svh"

module ring_road_traffic_automaton_step_unit #(
	parameter int ROAD_CELLS = rrta_pkg::ROAD_CELLS_DEF,
	parameter int MAX_CARS   = rrta_pkg::MAX_CARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rrta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrta_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rrta_cmd_if.sink                        cmd,
	rrta_rsp_if.source                      rsp
);

	localparam int SPD_W  = rrta_pkg::SPEED_W;
	localparam int PCT_W  = rrta_pkg::PCT_W;
	localparam int CELL_W = (ROAD_CELLS > 1) ? $clog2(ROAD_CELLS) : 1;
	localparam int CAR_AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
	localparam int CNT_NW = $clog2(MAX_CARS + 1);
	localparam int N_W    = (CNT_NW > rrta_pkg::CAR_COUNT_W) ? CNT_NW : rrta_pkg::CAR_COUNT_W;
	localparam int WORD_W = CELL_W + SPD_W + 1;
	localparam int GW     = ((CELL_W > SPD_W) ? CELL_W : SPD_W) + 1;
	localparam int PROD_W = 2 * PCT_W;
	localparam int K_W    = PCT_W + 1;
	localparam int K100_W = PROD_W + 1;

	// Configuration registers.
	logic [SPD_W-1:0]                    max_speed_q;
	logic [PCT_W-1:0]                    dawdle_q;
	logic [PCT_W-1:0]                    restart_q;
	logic                                cruise_q;
	logic [rrta_pkg::CAR_COUNT_W-1:0]    car_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= rrta_pkg::MAX_SPEED_RST;
			dawdle_q    <= rrta_pkg::DAWDLE_PCT_RST;
			restart_q   <= rrta_pkg::RESTART_PCT_RST;
			cruise_q    <= rrta_pkg::CRUISE_RST;
			car_count_q <= rrta_pkg::CAR_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rrta_pkg::REG_MAX_SPEED: begin
					max_speed_q <= cfg_wdata[SPD_W-1:0];
				end
				rrta_pkg::REG_DAWDLE_PCT: begin
					dawdle_q <= cfg_wdata[PCT_W-1:0];
				end
				rrta_pkg::REG_RESTART_PCT: begin
					restart_q <= cfg_wdata[PCT_W-1:0];
				end
				rrta_pkg::REG_CRUISE_ENABLE: begin
					cruise_q <= cfg_wdata[0];
				end
				rrta_pkg::REG_CAR_COUNT: begin
					car_count_q <= cfg_wdata[rrta_pkg::CAR_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Effective settings: probabilities capped at a full 100 percent, car count kept
	// between one and the size of the car store.
	logic [PCT_W-1:0] dd;
	logic [PCT_W-1:0] re;
	logic             re_on;
	logic [N_W-1:0]   n_cars;

	assign dd    = (dawdle_q > rrta_pkg::PCT_FULL) ? rrta_pkg::PCT_FULL : dawdle_q;
	assign re    = (restart_q > rrta_pkg::PCT_FULL) ? rrta_pkg::PCT_FULL : restart_q;
	assign re_on = (re != '0);

	always_comb begin
		if (car_count_q == '0) begin
			n_cars = N_W'(1);
		end else if (N_W'(car_count_q) > N_W'(MAX_CARS)) begin
			n_cars = N_W'(MAX_CARS);
		end else begin
			n_cars = N_W'(car_count_q);
		end
	end

	// Pipeline control.
	logic valid_s1;
	logic out_valid_q;
	logic out_free;
	logic s1_done;
	logic accept;
	logic step_acc;
	logic load_ok;
	logic enter_s1;

	assign out_free  = !out_valid_q || rsp.ready;
	assign s1_done   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;
	assign accept    = cmd.valid && cmd.ready;
	assign step_acc  = accept && (cmd.operation == rrta_pkg::OP_STEP);
	assign load_ok   = 32'(cmd.car_index) < 32'(MAX_CARS);
	assign enter_s1  = accept && ((cmd.operation == rrta_pkg::OP_STEP) || load_ok);

	// Step cursor: picks the car served by the next step transaction.
	logic [CAR_AW-1:0] cursor_q;
	logic [CAR_AW-1:0] idx0;
	logic [CAR_AW-1:0] next_idx0;
	logic [CAR_AW-1:0] ahead_addr0;
	logic              last0;

	assign idx0        = (N_W'(cursor_q) >= n_cars) ? '0 : cursor_q;
	assign last0       = (N_W'(idx0) == (n_cars - N_W'(1)));
	assign next_idx0   = last0 ? '0 : (idx0 + CAR_AW'(1));
	assign ahead_addr0 = idx0 + CAR_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (step_acc) begin
			cursor_q <= next_idx0;
		end
	end

	// Entry stage: load values, target car and the two dawdle tests.
	logic [CAR_AW-1:0]  addr0;
	logic [CELL_W-1:0]  load_cell0;
	logic [SPD_W-1:0]   load_spd0;
	logic [PROD_W-1:0]  restart_prod0;
	logic [K_W-1:0]     excess0;
	logic [K100_W-1:0]  excess100;
	logic               dawdle_hit0;
	logic               restart_hit0;

	assign addr0      = (cmd.operation == rrta_pkg::OP_STEP) ? idx0 : CAR_AW'(cmd.car_index);
	assign load_cell0 = CELL_W'(rrta_pkg::cell_reduce(cmd.cell_req, ROAD_CELLS));
	assign load_spd0  = (cmd.speed > max_speed_q) ? max_speed_q : cmd.speed;

	// The restart threshold is dd + floor((100 - dd) * re / 100). Beyond dd the draw is
	// below it exactly when 100 * (draw - dd + 1) fits within the product.
	assign dawdle_hit0   = cmd.random_percent < dd;
	assign restart_prod0 = PROD_W'(rrta_pkg::PCT_FULL - dd) * PROD_W'(re);
	assign excess0       = K_W'(cmd.random_percent) - K_W'(dd) + K_W'(1);
	assign excess100     = K100_W'(excess0) * K100_W'(rrta_pkg::PCT_FULL);
	assign restart_hit0  = dawdle_hit0 || (excess100 <= K100_W'(restart_prod0));

	// Car RAM: {restart flag, speed, cell}. The flag is written with every cell, so a
	// loaded car always carries a defined flag.
	logic               wr_en;
	logic [CAR_AW-1:0]  wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic [WORD_W-1:0]  rd_a;
	logic [WORD_W-1:0]  rd_b;

	rrta_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_CARS)
	) u_car_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.re      (enter_s1),
		.raddr_a (idx0),
		.raddr_b (ahead_addr0),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Update stage registers.
	logic [rrta_pkg::OP_W-1:0] op_s1;
	logic [CAR_AW-1:0]         addr_s1;
	logic                      last_s1;
	logic [CELL_W-1:0]         load_cell_s1;
	logic [SPD_W-1:0]          load_spd_s1;
	logic                      dawdle_hit_s1;
	logic                      restart_hit_s1;
	logic                      fwd_a_s1;
	logic                      fwd_b_s1;
	logic [WORD_W-1:0]         byp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enter_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	// A write-back in the same cycle as the RAM read is forwarded from the bypass register.
	always_ff @(posedge clk) begin
		if (enter_s1) begin
			op_s1          <= cmd.operation;
			addr_s1        <= addr0;
			last_s1        <= last0;
			load_cell_s1   <= load_cell0;
			load_spd_s1    <= load_spd0;
			dawdle_hit_s1  <= dawdle_hit0;
			restart_hit_s1 <= restart_hit0;
			fwd_a_s1       <= s1_done && (wr_addr == idx0);
			fwd_b_s1       <= s1_done && (wr_addr == ahead_addr0);
		end
		if (s1_done) begin
			byp_q <= wr_data;
		end
	end

	// Current car and the cell of the car ahead.
	logic [WORD_W-1:0] word_a;
	logic [WORD_W-1:0] word_b;
	logic [CELL_W-1:0] my_cell;
	logic [SPD_W-1:0]  v0;
	logic              flag0;
	logic              is_first;
	logic [CELL_W-1:0] first_old_q;
	logic [CELL_W-1:0] ahead_cell;

	assign word_a   = fwd_a_s1 ? byp_q : rd_a;
	assign word_b   = fwd_b_s1 ? byp_q : rd_b;
	assign my_cell  = word_a[CELL_W-1:0];
	assign v0       = word_a[CELL_W +: SPD_W];
	assign flag0    = word_a[WORD_W-1];
	assign is_first = (addr_s1 == '0);

	// The last car follows car 0 as it stood before car 0 moved in this tick.
	always_comb begin
		if (!last_s1) begin
			ahead_cell = word_b[CELL_W-1:0];
		end else if (is_first) begin
			ahead_cell = my_cell;
		end else begin
			ahead_cell = first_old_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_old_q <= '0;
		end else if (s1_done && (op_s1 == rrta_pkg::OP_STEP) && is_first) begin
			first_old_q <= my_cell;
		end
	end

	// Rules of one step: slow-to-start mark, accelerate, keep the gap, dawdle, advance.
	logic              flag1;
	logic              flag2;
	logic [SPD_W-1:0]  v1;
	logic [SPD_W-1:0]  v2;
	logic [SPD_W-1:0]  v3;
	logic [GW-1:0]     gap;
	logic [GW-1:0]     moved;
	logic [CELL_W-1:0] step_cell;

	assign flag1 = flag0 || (re_on && (v0 == '0));
	assign v1    = (v0 < max_speed_q) ? (v0 + SPD_W'(1)) : v0;

	always_comb begin
		if (ahead_cell > my_cell) begin
			gap = GW'(ahead_cell) - GW'(my_cell) - GW'(1);
		end else begin
			gap = GW'(ROAD_CELLS - 1) - GW'(my_cell) + GW'(ahead_cell);
		end
	end

	assign v2 = (GW'(v1) > gap) ? SPD_W'(gap) : v1;

	always_comb begin
		v3    = v2;
		flag2 = flag1;
		if (v2 != '0) begin
			if (re_on && flag1) begin
				flag2 = 1'b0;
				if (restart_hit_s1) begin
					v3 = v2 - SPD_W'(1);
				end
			end else if (!(cruise_q && (v2 >= max_speed_q)) && dawdle_hit_s1) begin
				v3 = v2 - SPD_W'(1);
			end
		end
	end

	// The move never reaches a full lap, so one subtraction wraps it.
	assign moved     = GW'(my_cell) + GW'(v3);
	assign step_cell = (moved >= GW'(ROAD_CELLS)) ? CELL_W'(moved - GW'(ROAD_CELLS))
		: CELL_W'(moved);

	// Write-back of the updated or loaded car.
	assign wr_en   = s1_done;
	assign wr_addr = addr_s1;
	assign wr_data = (op_s1 == rrta_pkg::OP_STEP) ? {flag2, v3, step_cell}
		: {1'b0, load_spd_s1, load_cell_s1};

	// Output register toward rsp.
	logic [rrta_pkg::CAR_ID_W-1:0]     car_id_q;
	logic [rrta_pkg::CELL_FIELD_W-1:0] new_cell_q;
	logic [SPD_W-1:0]                  new_speed_q;
	logic                              tick_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			car_id_q <= rrta_pkg::CAR_ID_W'(addr_s1);
			if (op_s1 == rrta_pkg::OP_STEP) begin
				new_cell_q  <= rrta_pkg::CELL_FIELD_W'(step_cell);
				new_speed_q <= v3;
				tick_done_q <= last_s1;
			end else begin
				new_cell_q  <= rrta_pkg::CELL_FIELD_W'(load_cell_s1);
				new_speed_q <= load_spd_s1;
				tick_done_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.car_id    = car_id_q;
	assign rsp.new_cell  = new_cell_q;
	assign rsp.new_speed = new_speed_q;
	assign rsp.tick_done = tick_done_q;

	// Checks on the cursor, the forwarding path and the stall behavior.
	`RRTA_ASSERT(a_cursor_in_range, step_acc |=> (N_W'(cursor_q) < $past(n_cars)), "step cursor beyond car count")
	`RRTA_ASSERT(a_fwd_needs_write, (valid_s1 && (fwd_a_s1 || fwd_b_s1) && $past(enter_s1)) |-> $past(s1_done), "forwarding without a write-back")
	`RRTA_ASSERT(a_hold_on_stall, (valid_s1 && !s1_done) |=> (valid_s1 && $stable(addr_s1) && $stable(op_s1)), "update stage lost its car while stalled")

endmodule
